[rtl/core/drbl_pkg.sv]
package drbl_pkg;

  localparam int CHANNELS    = 16;
  localparam int GROUP_COUNT = 5;
  localparam int GROUP_WIDTH = 3;

  localparam int RAW_W = 16;
  localparam int CNT_W = 9;
  localparam int DEB_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [DEB_W-1:0] DEB_RESET = DEB_W'(20);

  typedef logic [CHANNELS-1:0] chan_vec_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [DEB_W-1:0]    deb_t;

endpackage

[rtl/core/drbl_debounce.sv]
module drbl_debounce (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  drbl_pkg::chan_vec_t raw,
  input  drbl_pkg::deb_t      debounce_ticks,
  output drbl_pkg::chan_vec_t rise
);
  import drbl_pkg::*;

  chan_vec_t prev_r;
  chan_vec_t stable_r;
  chan_vec_t stable_nxt;
  cnt_t      cnt_r   [CHANNELS];
  cnt_t      cnt_nxt [CHANNELS];

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      if (raw[i] != prev_r[i]) begin
        cnt_nxt[i] = '0;
      end else if (cnt_r[i] == CNT_MAX) begin
        cnt_nxt[i] = CNT_MAX;
      end else begin
        cnt_nxt[i] = cnt_r[i] + cnt_t'(1);
      end
      if ((cnt_nxt[i] > cnt_t'(debounce_ticks)) && (raw[i] != stable_r[i])) begin
        stable_nxt[i] = raw[i];
        rise[i]       = raw[i];
      end else begin
        stable_nxt[i] = stable_r[i];
        rise[i]       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      stable_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= CNT_MAX;
      end
    end else if (advance) begin
      prev_r   <= raw;
      stable_r <= stable_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule

[rtl/core/debounced_radio_button_latch_core.sv]
// Path: an accepted input word passes the input register, then the result register.
// Throughput: one word per cycle while out_tready does not stall it; the per-channel
// debounce and group exclusion sit in one stage between the input and result registers.
// Reset (rst_n low at a clock edge): counters saturated, levels and latches
// cleared, debounce threshold back to 20, both registers empty.
module debounced_radio_button_latch_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] raw_buttons
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] latched_word
  output logic        out_tuser,  // [0] word_changed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import drbl_pkg::*;

  logic      in_v_r;
  chan_vec_t raw_r;
  deb_t      deb_r;
  logic      advance;
  chan_vec_t rise;
  chan_vec_t fresh;
  chan_vec_t latch_r;
  chan_vec_t latch_nxt;
  logic      out_v_r;
  logic      changed_r;

  function automatic logic groups_ok(chan_vec_t w);
    logic ok;
    int   n;
    ok = 1'b1;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      n = 0;
      for (int j = 0; j < GROUP_WIDTH; j++) begin
        if ((g * GROUP_WIDTH + j) < CHANNELS) begin
          n = n + int'(w[g * GROUP_WIDTH + j]);
        end
      end
      if (n > 1) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || advance;
  assign cfg_ready = 1'b1;

  drbl_debounce u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .raw            (raw_r),
    .debounce_ticks (deb_r),
    .rise           (rise)
  );

  assign fresh = rise & ~latch_r;

  always_comb begin
    int win;
    latch_nxt = latch_r | rise;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      win = -1;
      for (int j = 0; j < GROUP_WIDTH; j++) begin
        if ((g * GROUP_WIDTH + j) < CHANNELS && fresh[g * GROUP_WIDTH + j]) begin
          win = g * GROUP_WIDTH + j;
        end
      end
      if (win >= 0) begin
        for (int j = 0; j < GROUP_WIDTH; j++) begin
          if ((g * GROUP_WIDTH + j) < CHANNELS && (g * GROUP_WIDTH + j) != win) begin
            latch_nxt[g * GROUP_WIDTH + j] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      latch_r <= '0;
      deb_r   <= DEB_RESET;
    end else begin
      if (cfg_valid) begin
        deb_r <= cfg_data;
      end
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        latch_r <= latch_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      raw_r <= chan_vec_t'(in_tdata);
    end
    if (advance) begin
      changed_r <= (latch_nxt != latch_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = latch_r[15:0];
  assign out_tuser  = changed_r;

  a_group_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    groups_ok(latch_r))
    else $error("more than one latch set in a group");

  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_tuser == (latch_r != $past(latch_r))))
    else $error("changed flag disagrees with latch word");

  a_latch_from_rise: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> ((latch_r & ~$past(latch_r) & ~$past(rise)) == '0))
    else $error("latch set without a stable rising edge");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(latch_r))
    else $error("latch word moved without an item");

endmodule

[tb/sv/tb_debounced_radio_button_latch_core.sv]
module tb_debounced_radio_button_latch_core;
  timeunit 1ns;
  timeprecision 1ps;

  import drbl_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int TAIL_CYCLES = 10;

  typedef struct packed {
    chan_vec_t latched;
    logic      changed;
  } latch_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  chan_vec_t  in_tdata = '0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic       out_tuser;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  deb_t       cfg_data = '0;

  chan_vec_t   raw_seen;
  chan_vec_t   level_seen;
  chan_vec_t   latch_seen;
  cnt_t        settle_cnt [CHANNELS];
  deb_t        debounce_th;
  latch_word_t pending_words [$];

  int err_count = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int hold_off_left = 0;
  int quiet_cycles = 0;

  debounced_radio_button_latch_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic latch_word_t advance_latches(chan_vec_t raw);
    chan_vec_t   prior;
    chan_vec_t   fresh;
    latch_word_t res;
    int          winner;
    int          ch;
    prior = latch_seen;
    for (int i = 0; i < CHANNELS; i++) begin
      if (raw[i] != raw_seen[i]) settle_cnt[i] = '0;
      else if (settle_cnt[i] != CNT_MAX) settle_cnt[i] = settle_cnt[i] + 1'b1;
      if (settle_cnt[i] > debounce_th && raw[i] != level_seen[i]) begin
        level_seen[i] = raw[i];
        if (raw[i]) latch_seen[i] = 1'b1;
      end
    end
    raw_seen = raw;
    fresh = latch_seen & ~prior;
    for (int g = 0; g < GROUP_COUNT; g++) begin
      winner = -1;
      for (int j = 0; j < GROUP_WIDTH; j++) begin
        ch = g * GROUP_WIDTH + j;
        if (ch < CHANNELS && fresh[ch]) winner = ch;
      end
      if (winner >= 0) begin
        for (int j = 0; j < GROUP_WIDTH; j++) begin
          ch = g * GROUP_WIDTH + j;
          if (ch < CHANNELS && ch != winner) latch_seen[ch] = 1'b0;
        end
      end
    end
    res.latched = latch_seen;
    res.changed = (latch_seen != prior);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // receiver: long hold-off first, random stalls otherwise
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      out_tready <= 1'b0;
      hold_off_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    latch_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word %h/%b with none expected", out_tdata, out_tuser));
      end else begin
        want = pending_words.pop_front();
        if (out_tdata !== want.latched)
          report_mismatch($sformatf("latched_word %h, want %h", out_tdata, want.latched));
        if (out_tuser !== want.changed)
          report_mismatch($sformatf("word_changed %b, want %b", out_tuser, want.changed));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TIMEOUT: no handshake for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_raw(input chan_vec_t raw);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    do @(posedge clk); while (!in_tready);
    pending_words.push_back(advance_latches(raw));
  endtask

  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_debounce(input deb_t ticks);
    release_input();
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    do @(posedge clk); while (!cfg_ready);
    debounce_th = ticks;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // well-formed presses with random content, mixed with short bursts of noise
  task automatic run_presses(input int budget);
    chan_vec_t held;
    int        hold_len;
    int        sent;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) < 7) begin
        held = $urandom_range(1) ? chan_vec_t'($urandom)
                                 : chan_vec_t'($urandom & $urandom & $urandom);
        hold_len = $urandom_range(int'(debounce_th) + 4, int'(debounce_th));
        repeat (hold_len) send_raw(held);
        held = held & chan_vec_t'($urandom);
        repeat (int'(debounce_th) + 2) send_raw(held);
        sent += hold_len + int'(debounce_th) + 2;
      end else begin
        repeat ($urandom_range(5, 1)) begin
          send_raw(chan_vec_t'($urandom));
          sent++;
        end
      end
    end
  endtask

  task automatic test_directed();
    gap_pct = 0;
    stall_pct = 0;
    // glitches at the reset threshold never settle
    send_raw(16'hFFFF);
    send_raw(16'h0000);
    write_debounce(8'd0);
    send_raw(16'hFFFF);
    send_raw(16'hFFFF);
    send_raw(16'h0000);
    send_raw(16'h0000);
    // two fresh latches in one group: the higher wins
    send_raw(16'h0003);
    send_raw(16'h0003);
    send_raw(16'h0000);
    send_raw(16'h0000);
    // channel 15 already latched and outside every group
    send_raw(16'h8001);
    send_raw(16'h8001);
    send_raw(16'h0001);
    send_raw(16'h0000);
    send_raw(16'h0001);
    send_raw(16'h0000);
    send_raw(16'hAAAA);
    send_raw(16'hAAAA);
    send_raw(16'h5555);
    send_raw(16'h5555);
    release_input();
  endtask

  task automatic test_free_flow();
    write_debounce(8'd1);
    gap_pct = 0;
    stall_pct = 0;
    run_presses(80);
    release_input();
  endtask

  task automatic test_sender_gaps();
    write_debounce(8'd3);
    gap_pct = 67;
    stall_pct = 0;
    run_presses(80);
    release_input();
  endtask

  task automatic test_receiver_stalls();
    write_debounce(8'd0);
    gap_pct = 0;
    stall_pct = 67;
    run_presses(80);
    release_input();
  endtask

  task automatic test_both_idle();
    write_debounce(8'd7);
    gap_pct = 19;
    stall_pct = 19;
    run_presses(80);
    release_input();
  endtask

  task automatic test_backpressure();
    write_debounce(8'd2);
    gap_pct = 0;
    stall_pct = 0;
    hold_off_left = 150;
    run_presses(50);
    release_input();
  endtask

  task automatic test_longest_debounce();
    chan_vec_t held;
    write_debounce(8'd255);
    gap_pct = 0;
    stall_pct = 0;
    held = chan_vec_t'($urandom) | 16'h0001;
    repeat (258) send_raw(held);
    repeat (4) send_raw(chan_vec_t'($urandom));
    release_input();
  endtask

  task automatic finish_run();
    release_input();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", pending_words.size()));
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  endtask

  initial begin
    raw_seen    = '0;
    level_seen  = '0;
    latch_seen  = '0;
    debounce_th = DEB_RESET;
    for (int i = 0; i < CHANNELS; i++) settle_cnt[i] = CNT_MAX;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_free_flow();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_backpressure();
    test_longest_debounce();
    finish_run();
  end

endmodule

[filelist.f]
rtl/core/drbl_pkg.sv
rtl/core/drbl_debounce.sv
rtl/core/debounced_radio_button_latch_core.sv
tb/sv/tb_debounced_radio_button_latch_core.sv
